// ----- rtl/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the paged bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

    localparam int unsigned PAGE_BW          = 25;
    localparam int unsigned BYTES_BW         = 24;
    localparam int unsigned PAGE_MIN_HEADERS = 16;

    localparam logic [PAGE_BW-1:0] PAGE_BYTES_RESET = 25'd1048576;
    localparam logic [PAGE_BW-1:0] PAGE_BYTES_CAP   = 25'd16777216;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_BIG  = 2'd2;
    localparam logic [1:0] STAT_FULL = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        K_RELEASE,
        K_ZERO,
        K_HIT,
        K_NOFIT
    } t_kind;

    typedef struct packed {
        logic  load;
        logic  scan_first;
        logic  scan_next;
        logic  finish;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic is_zero;
        logic count_zero;
        logic fit;
        logic k_zero;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [PAGE_BW-1:0] free_bytes;
        logic [PAGE_BW-1:0] next_offset;
    } t_page_entry;

endpackage

`default_nettype wire

// ----- rtl/pba_ctrl.sv -----
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer: request decode, newest-first page scan, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  pba_pkg::t_stat i_stat,
    output pba_pkg::t_cmd  o_cmd
);
    import pba_pkg::*;

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_RELEASE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.is_release) begin
                    n_kind  = K_RELEASE;
                    n_state = S_FINISH;
                end else if (i_stat.is_zero) begin
                    n_kind  = K_ZERO;
                    n_state = S_FINISH;
                end else if (i_stat.count_zero) begin
                    n_kind  = K_NOFIT;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.fit) begin
                    n_kind  = K_HIT;
                    n_state = S_FINISH;
                end else if (i_stat.k_zero) begin
                    n_kind  = K_NOFIT;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.scan_first = 1'b0;
        o_cmd.scan_next  = 1'b0;
        o_cmd.finish     = 1'b0;
        o_cmd.kind       = r_kind;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DISPATCH: begin
                o_cmd.scan_first = !i_stat.is_release && !i_stat.is_zero &&
                                   !i_stat.count_zero;
            end
            S_SCAN: begin
                o_cmd.scan_next = !i_stat.fit && !i_stat.k_zero;
            end
            S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/pba_datapath.sv -----
// ----------------------------------------------------------------------------
// pba_datapath
// Page table memory, page count, config register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_datapath #(
    parameter int unsigned MAX_PAGES    = 16,
    parameter int unsigned HEADER_BYTES = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [pba_pkg::PAGE_BW-1:0]   i_cfg_data,
    input  wire                           i_req_type,
    input  wire  [pba_pkg::BYTES_BW-1:0]  i_alloc_bytes,
    input  pba_pkg::t_cmd                 i_cmd,
    output pba_pkg::t_stat                o_stat,
    input  wire                           i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic [3:0]                    o_page_index,
    output logic [pba_pkg::BYTES_BW-1:0]  o_byte_offset,
    output logic                          o_opened_page,
    output logic [4:0]                    o_page_count
);
    import pba_pkg::*;

    localparam int unsigned IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned CW = $clog2(MAX_PAGES + 1);
    localparam logic [PAGE_BW-1:0] HDR      = PAGE_BW'(HEADER_BYTES);
    localparam logic [PAGE_BW-1:0] PAGE_MIN = PAGE_BW'(HEADER_BYTES * PAGE_MIN_HEADERS);

    t_page_entry         r_mem [0:MAX_PAGES-1];
    t_page_entry         r_rd;
    logic                r_req;
    logic [BYTES_BW-1:0] r_bytes;
    logic [PAGE_BW-1:0]  r_page_bytes;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_k;
    logic                r_out_valid;
    logic [1:0]          r_status, n_status;
    logic [3:0]          r_idx, n_idx;
    logic [BYTES_BW-1:0] r_off, n_off;
    logic                r_opened, n_opened;
    logic [4:0]          r_cnt_out;

    logic [IW-1:0]       last_idx;
    logic [IW-1:0]       raddr;
    logic                we;
    logic [IW-1:0]       waddr;
    t_page_entry         wdata;
    logic [PAGE_BW-1:0]  bytes_ext;
    logic [PAGE_BW-1:0]  usable;
    logic                too_big;
    logic                full;

    assign bytes_ext = {1'b0, r_bytes};
    assign usable    = r_page_bytes - HDR;
    assign too_big   = bytes_ext > usable;
    assign full      = r_count == CW'(MAX_PAGES);
    assign last_idx  = IW'(r_count - CW'(1));
    assign raddr     = i_cmd.scan_first ? last_idx : r_k - IW'(1);

    assign o_stat.is_release = r_req == REQ_RELEASE;
    assign o_stat.is_zero    = r_bytes == '0;
    assign o_stat.count_zero = r_count == '0;
    assign o_stat.fit        = r_rd.free_bytes >= bytes_ext;
    assign o_stat.k_zero     = r_k == '0;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_count  = r_count;
        n_status = STAT_OK;
        n_idx    = '0;
        n_off    = '0;
        n_opened = 1'b0;
        we       = 1'b0;
        waddr    = r_k;
        wdata    = r_rd;
        case (i_cmd.kind)
            K_RELEASE: begin
                n_count = '0;
            end
            K_ZERO: begin
                n_status = STAT_ZERO;
            end
            K_HIT: begin
                we                = 1'b1;
                wdata.free_bytes  = r_rd.free_bytes - bytes_ext;
                wdata.next_offset = r_rd.next_offset + bytes_ext;
                n_idx             = 4'(r_k);
                n_off             = r_rd.next_offset[BYTES_BW-1:0];
            end
            K_NOFIT: begin
                if (too_big) begin
                    n_status = STAT_BIG;
                end else if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    we                = 1'b1;
                    waddr             = r_count[IW-1:0];
                    wdata.free_bytes  = usable - bytes_ext;
                    wdata.next_offset = HDR + bytes_ext;
                    n_idx             = 4'(r_count);
                    n_off             = HDR[BYTES_BW-1:0];
                    n_opened          = 1'b1;
                    n_count           = r_count + CW'(1);
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && we) r_mem[waddr] <= wdata;
        if (i_cmd.scan_first || i_cmd.scan_next) r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_bytes <= i_alloc_bytes;
        end
        if (i_cmd.scan_first) begin
            r_k <= last_idx;
        end else if (i_cmd.scan_next) begin
            r_k <= r_k - IW'(1);
        end
        if (i_cmd.finish) begin
            r_status  <= n_status;
            r_idx     <= n_idx;
            r_off     <= n_off;
            r_opened  <= n_opened;
            r_cnt_out <= 5'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_page_bytes <= PAGE_BYTES_RESET;
        end else begin
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_data < PAGE_MIN) begin
                    r_page_bytes <= PAGE_MIN;
                end else if (i_cfg_data > PAGE_BYTES_CAP) begin
                    r_page_bytes <= PAGE_BYTES_CAP;
                end else begin
                    r_page_bytes <= i_cfg_data;
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_page_index  = r_idx;
    assign o_byte_offset = r_off;
    assign o_opened_page = r_opened;
    assign o_page_count  = r_cnt_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAGES))
        else $error("page count above table size");

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending transaction");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && i_cmd.kind == K_RELEASE) |=> (r_count == '0 && r_out_valid))
        else $error("release did not drop pages");

    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page_bytes >= PAGE_MIN && r_page_bytes <= PAGE_BYTES_CAP)
        else $error("page size out of range");

    a_open_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && n_opened) |=> r_count == $past(r_count) + CW'(1))
        else $error("page open did not bump count");

endmodule

`default_nettype wire

// ----- rtl/paged_bump_allocator.sv -----
// ----------------------------------------------------------------------------
// paged_bump_allocator
// Region allocator over a table of pages with a newest-first fit search.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser is the request type (0
// allocate, 1 release all pages), tdata the byte count. Each request gives one
// transaction on m_axis: tuser is the status, tdata the page index, byte
// offset, opened flag and page count.
// The page size register is to be written with i_cfg_we / i_cfg_data only
// while idle, which the block does not enforce; the value is clamped to
// [16 * HEADER_BYTES, 2^24] on write. A release or zero-size request passes
// through dispatch straight to the finish step; an allocate first scans the
// page table memory newest first, one entry per cycle, until an entry fits or
// none is left (1 to MAX_PAGES entries read, none when no page is open). A
// new request is accepted only in the idle state, entered once the result is
// registered, so one request is in work at a time.
// Reset clears the page count, the result valid flag and restores the page
// size to 1 MiB; the page table itself needs no clearing.
// When the receiver stalls, the result is held in the output register; one
// further request is accepted and finishes up to its final step, then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_bump_allocator #(
    parameter int unsigned MAX_PAGES    = 16,
    parameter int unsigned HEADER_BYTES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [24:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [23:0] alloc_bytes
    input  wire  [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] page_index, [27:4] byte_offset,
                                        // [28] opened_page, [33:29] page_count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import pba_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic [1:0]          status;
    logic [3:0]          page_index;
    logic [BYTES_BW-1:0] byte_offset;
    logic                opened_page;
    logic [4:0]          page_count;

    pba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pba_datapath #(
        .MAX_PAGES    (MAX_PAGES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (s_axis_tuser[0]),
        .i_alloc_bytes (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (status),
        .o_page_index  (page_index),
        .o_byte_offset (byte_offset),
        .o_opened_page (opened_page),
        .o_page_count  (page_count)
    );

    assign m_axis_tdata = {6'b0, page_count, opened_page, byte_offset, page_index};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire
